@@ src/decimal_scaled_long_division_unit_macros.svh @@
// Assertion helpers shared by the divider modules.
`ifndef DECIMAL_SCALED_LONG_DIVISION_UNIT_MACROS_SVH
`define DECIMAL_SCALED_LONG_DIVISION_UNIT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define DSLD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define DSLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/dsld_pkg.sv @@
`default_nettype none

package dsld_pkg;

   localparam int WORD_W     = 64;
   localparam int PLACES_W   = 5;
   localparam int DIGIT_BITS = 4;
   localparam int CNT_W      = 7;
   localparam int PRE_SHIFT  = 4;

   localparam logic [WORD_W-1:0] TOP_SIX_MASK = 64'hFC00_0000_0000_0000;

   typedef struct packed {
      logic signed [WORD_W-1:0] numerator;
      logic signed [WORD_W-1:0] denominator;
      logic [PLACES_W-1:0]      decimal_places;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] scaled_quotient;
      logic                     divide_by_zero;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic digit;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] x);
      return x[WORD_W-1] ? WORD_W'(-x) : x;
   endfunction

endpackage

`default_nettype wire

@@ src/dsld_div_core.sv @@
`default_nettype none

`include "decimal_scaled_long_division_unit_macros.svh"

module dsld_div_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dsld_pkg::div_cmd_type         cmd,
   input  wire logic [dsld_pkg::WORD_W-1:0]   dividend,
   input  wire logic [dsld_pkg::WORD_W-1:0]   divisor,
   output dsld_pkg::div_sts_type              sts,
   output logic [dsld_pkg::WORD_W-1:0]        quotient,
   output logic [dsld_pkg::WORD_W-1:0]        remainder
);

   localparam int W = dsld_pkg::WORD_W;
   localparam int D = dsld_pkg::DIGIT_BITS;

   logic [W-1:0]                 rem_ff, rem_in;
   logic [W-1:0]                 quo_ff, quo_in;
   logic [dsld_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                         run_ff, run_in;
   logic                         done_ff, done_in;
   logic [W:0]                   trial;
   logic [W:0]                   diff;
   logic                         fits;

   // One restoring step: bring down the next dividend bit and try a subtract.
   assign trial = {rem_ff, quo_ff[W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (run_ff) begin
         rem_in = fits ? diff[W-1:0] : trial[W-1:0];
         quo_in = {quo_ff[W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == dsld_pkg::CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         run_in = 1'b1;
         if (cmd.digit) begin
            // The quotient is below ten, so the top bits are already a valid
            // partial remainder and only the last four bits need stepping.
            rem_in = W'(dividend[W-1:D]);
            quo_in = {dividend[D-1:0], {(W-D){1'b0}}};
            cnt_in = dsld_pkg::CNT_W'(D);
         end else begin
            rem_in = '0;
            quo_in = dividend;
            cnt_in = dsld_pkg::CNT_W'(W);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign sts.busy  = run_ff;
   assign sts.done  = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   `DSLD_ASSERT_NOW(a_rem_below_divisor, clock, reset, run_ff, rem_ff < divisor, "partial remainder not below divisor")
   `DSLD_ASSERT_NEXT(a_start_runs, clock, reset, cmd.start && !run_ff, run_ff, "start did not begin a division")
   `DSLD_ASSERT_NOW(a_done_idle, clock, reset, done_ff, !run_ff, "done raised while still stepping")

endmodule

`default_nettype wire

@@ src/decimal_scaled_long_division_unit.sv @@
// Channel   Ports                         Handshake
// request   start, busy, req_payload      taken when start is high and busy is low
// result    rsp_valid, rsp_payload        shown for one cycle, always taken
//
// From acceptance to the result strobe, a request is worked out in passes:
// one 64-step radix-2 pass for the integer part, then a four-step pass for each
// decimal place, all on the one shared compare-subtract unit in dsld_div_core.
// A zero denominator is flagged in ST_PREP, with no pass at all. busy is high
// from acceptance until the result is shown; reset is synchronous and clears all
// control state. The receiver cannot stall, so a result is never held back.
`default_nettype none

`include "decimal_scaled_long_division_unit_macros.svh"

module decimal_scaled_long_division_unit #(
   parameter int MAX_PLACES = 18
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire dsld_pkg::req_type req_payload,
   output logic                   busy,
   output logic                   rsp_valid,
   output dsld_pkg::rsp_type      rsp_payload
);

   localparam int W  = dsld_pkg::WORD_W;
   localparam int PW = dsld_pkg::PLACES_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PREP   = 3'd1;
   localparam logic [2:0] ST_SETUP  = 3'd2;
   localparam logic [2:0] ST_LOAD   = 3'd3;
   localparam logic [2:0] ST_WAIT   = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [W-1:0]      num_ff, num_in;
   logic [W-1:0]      den_ff, den_in;
   logic [W-1:0]      ud_ff, ud_in;
   logic [W-1:0]      result_ff, result_in;
   logic [PW-1:0]     places_ff, places_in;
   logic              first_ff, first_in;
   logic              nneg_ff, nneg_in;
   logic              dneg_ff, dneg_in;
   logic              rsp_valid_ff, rsp_valid_in;
   dsld_pkg::rsp_type rsp_ff, rsp_in;

   dsld_pkg::div_cmd_type div_cmd;
   dsld_pkg::div_sts_type div_sts;
   logic [W-1:0]          div_quo;
   logic [W-1:0]          div_rem;
   logic [PW-1:0]         places_sat;
   logic [W-1:0]          quo_signed;
   logic [W-1:0]          rem_signed;
   logic [W-1:0]          result_next;

   assign places_sat = (req_payload.decimal_places > PW'(MAX_PLACES)) ?
                       PW'(MAX_PLACES) : req_payload.decimal_places;

   assign div_cmd.start = (state_ff == ST_LOAD);
   assign div_cmd.digit = !first_ff;

   dsld_div_core u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .dividend  (dsld_pkg::magnitude(num_ff)),
      .divisor   (ud_ff),
      .sts       (div_sts),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Truncating signs: quotient negative when the signs differ, remainder
   // follows the dividend.
   assign quo_signed  = (nneg_ff != dneg_ff) ? W'(-div_quo) : div_quo;
   assign rem_signed  = nneg_ff ? W'(-div_rem) : div_rem;
   assign result_next = (result_ff << 3) + (result_ff << 1) + quo_signed;

   always_comb begin
      state_in     = state_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      ud_in        = ud_ff;
      result_in    = result_ff;
      places_in    = places_ff;
      first_in     = first_ff;
      nneg_in      = nneg_ff;
      dneg_in      = dneg_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               num_in    = req_payload.numerator;
               den_in    = req_payload.denominator;
               places_in = places_sat;
               state_in  = ST_PREP;
            end
         end
         ST_PREP: begin
            first_in  = 1'b1;
            result_in = '0;
            if (den_ff == '0) begin
               rsp_in.scaled_quotient = '0;
               rsp_in.divide_by_zero  = 1'b1;
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end else begin
               // Large divisors are scaled down so that ten times a remainder
               // stays within the word as far as possible.
               if ((dsld_pkg::magnitude(den_ff) & dsld_pkg::TOP_SIX_MASK) != '0) begin
                  num_in = $signed(num_ff) >>> dsld_pkg::PRE_SHIFT;
                  den_in = $signed(den_ff) >>> dsld_pkg::PRE_SHIFT;
               end
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            ud_in    = dsld_pkg::magnitude(den_ff);
            dneg_in  = den_ff[W-1];
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            nneg_in  = num_ff[W-1];
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_sts.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            result_in = result_next;
            num_in    = (rem_signed << 3) + (rem_signed << 1);
            first_in  = 1'b0;
            if (places_ff == '0) begin
               rsp_in.scaled_quotient = result_next;
               rsp_in.divide_by_zero  = 1'b0;
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end else begin
               places_in = places_ff - 1'b1;
               state_in  = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b1;
         places_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
         places_ff    <= places_in;
      end
      num_ff    <= num_in;
      den_ff    <= den_in;
      ud_ff     <= ud_in;
      result_ff <= result_in;
      nneg_ff   <= nneg_in;
      dneg_ff   <= dneg_in;
      rsp_ff    <= rsp_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `DSLD_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid, "result strobe held longer than one cycle")
   `DSLD_ASSERT_NOW(a_zero_result, clock, reset, rsp_valid && rsp_payload.divide_by_zero, rsp_payload.scaled_quotient == '0, "divide by zero with nonzero quotient")
   `DSLD_ASSERT_NOW(a_idle_core_quiet, clock, reset, state_ff == ST_IDLE, !div_sts.busy, "divider stepping while the block is idle")

endmodule

`default_nettype wire
